>>> sv/akl_pkg.sv
// Shared types and constants of the adaptive key table lookup
`timescale 1ns / 1ps
`default_nettype none
package akl_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 256;
	localparam int unsigned KEY_W           = 32;
	localparam int unsigned INDEX_W         = 8;

	typedef logic [1:0] command_t;
	localparam command_t CMD_CLEAR  = 2'd0;
	localparam command_t CMD_APPEND = 2'd1;
	localparam command_t CMD_LOOKUP = 2'd2;

	typedef logic [1:0] method_t;
	localparam method_t METH_LINEAR = 2'd0;
	localparam method_t METH_BINARY = 2'd1;
	localparam method_t METH_DIRECT = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
		logic cls_init;
		logic cls_step;
		logic pick;
		logic bs_rd;
		logic bs_cmp;
		logic bs_fin;
		logic ls_step;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic    lookup;
		logic    classified;
		method_t mode;
		logic    cls_done;
		logic    bs_more;
		logic    ls_done;
		logic    out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> sv/adaptive_key_table_lookup.sv
// Clear and append pass through idle, execute and finish states; a direct lookup also passes the pick state.
// Binary lookup: each probe of the table RAM takes a read state and a compare state.
// Linear lookup: one RAM read per cycle until the first match or the last entry.
// The first lookup after a change adds a classifying walk through the stored keys.
// One request at a time; a finished result waits in the output register.
// Reset clears count, mode and handshake state; table RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_key_table_lookup #(
	parameter int unsigned TABLE_DEPTH = akl_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire akl_pkg::command_t            command,
	input  wire logic [akl_pkg::KEY_W-1:0]    key,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              found,
	output logic      [akl_pkg::INDEX_W-1:0]  match_index,
	output akl_pkg::method_t                  method,
	output logic                              table_full
);
	import akl_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	akl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	akl_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.command    (command),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.match_index(match_index),
		.method     (method),
		.table_full (table_full)
	);

endmodule
`default_nettype wire

>>> sv/akl_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module akl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> sv/akl_ctrl.sv
// Controller state machine of the adaptive key table lookup
`timescale 1ns / 1ps
`default_nettype none
module akl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire akl_pkg::stat_t stat,
	output akl_pkg::ctrl_t      ctrl
);
	import akl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CLS,
		S_PICK,
		S_BS_RD,
		S_BS_CMP,
		S_LS,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		ctrl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_nx  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctrl.exec = 1'b1;
				if (!stat.lookup) begin
					state_nx = S_FIN;
				end else if (stat.classified) begin
					state_nx = S_PICK;
				end else begin
					ctrl.cls_init = 1'b1;
					state_nx      = S_CLS;
				end
			end
			S_CLS: begin
				ctrl.cls_step = 1'b1;
				if (stat.cls_done) begin
					state_nx = S_PICK;
				end
			end
			S_PICK: begin
				ctrl.pick = 1'b1;
				case (stat.mode)
					METH_DIRECT: state_nx = S_FIN;
					METH_BINARY: state_nx = S_BS_RD;
					default:     state_nx = S_LS;
				endcase
			end
			S_BS_RD: begin
				if (stat.bs_more) begin
					ctrl.bs_rd = 1'b1;
					state_nx   = S_BS_CMP;
				end else begin
					ctrl.bs_fin = 1'b1;
					state_nx    = S_FIN;
				end
			end
			S_BS_CMP: begin
				ctrl.bs_cmp = 1'b1;
				state_nx    = S_BS_RD;
			end
			S_LS: begin
				ctrl.ls_step = 1'b1;
				if (stat.ls_done) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					state_nx  = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

>>> sv/akl_dp.sv
// Datapath of the adaptive key table lookup: table, classifier, searches, result
`timescale 1ns / 1ps
`default_nettype none
module akl_dp #(
	parameter int unsigned TABLE_DEPTH = akl_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire akl_pkg::ctrl_t               ctrl,
	output akl_pkg::stat_t                    stat,
	input  wire akl_pkg::command_t            command,
	input  wire logic [akl_pkg::KEY_W-1:0]    key,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              found,
	output logic      [akl_pkg::INDEX_W-1:0]  match_index,
	output akl_pkg::method_t                  method,
	output logic                              table_full
);
	import akl_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [KEY_W-1:0] base_q;
	method_t          mode_q;
	logic             classified_q;
	logic             out_valid_q;
	logic             pend_q;

	command_t         cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    ptr_q;
	logic [AW-1:0]    chk_q;
	method_t          cmode_q;
	logic [KEY_W-1:0] prev_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    mid_q;
	logic             eq_q;
	logic             res_found_q;
	logic [AW-1:0]    res_idx_q;
	method_t          res_method_q;
	logic             res_full_q;
	logic             found_q;
	logic [INDEX_W-1:0] match_index_q;
	method_t          method_q;
	logic             table_full_q;

	logic             full;
	logic             issue;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [KEY_W-1:0] rd_data;
	logic [CW-1:0]    mid_c;
	logic             last;
	logic             hit;
	method_t          cmode_nx;
	logic             cls_done;
	logic             ls_done;
	logic [KEY_W-1:0] diff;
	logic             direct_hit;
	logic [AW+INDEX_W-1:0] idx_wide;

	akl_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(key_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign full       = (count_q == CW'(TABLE_DEPTH));
	assign wr_en      = ctrl.exec && (cmd_q == CMD_APPEND) && !full;
	assign issue      = (ptr_q < count_q);
	assign mid_c      = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_en      = ctrl.bs_rd || ((ctrl.cls_step || ctrl.ls_step) && issue);
	assign rd_addr    = ctrl.bs_rd ? mid_c[AW-1:0] : ptr_q[AW-1:0];
	assign last       = (CW'(chk_q) == (count_q - CW'(1)));
	assign hit        = (rd_data == key_q);
	assign diff       = key_q - base_q;
	assign direct_hit = (diff < KEY_W'(count_q));
	assign idx_wide   = {{INDEX_W{1'b0}}, res_idx_q};

	always_comb begin
		cmode_nx = cmode_q;
		if (pend_q && (chk_q != '0)) begin
			if ((cmode_nx == METH_DIRECT) && (rd_data != (base_q + KEY_W'(chk_q)))) begin
				cmode_nx = METH_BINARY;
			end
			if ((cmode_nx == METH_BINARY) && ((prev_q > rd_data) || (base_q > rd_data))) begin
				cmode_nx = METH_LINEAR;
			end
		end
	end

	assign cls_done = (count_q == '0) || (pend_q && (last || (cmode_nx == METH_LINEAR)));
	assign ls_done  = (count_q == '0) || (pend_q && (hit || last));

	always_comb begin
		stat            = '0;
		stat.lookup     = (cmd_q == CMD_LOOKUP);
		stat.classified = classified_q;
		stat.mode       = mode_q;
		stat.cls_done   = cls_done;
		stat.bs_more    = (lo_q < hi_q);
		stat.ls_done    = ls_done;
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			base_q       <= '0;
			mode_q       <= METH_DIRECT;
			classified_q <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			if (ctrl.exec) begin
				case (cmd_q)
					CMD_CLEAR: begin
						count_q      <= '0;
						base_q       <= '0;
						mode_q       <= METH_DIRECT;
						classified_q <= 1'b0;
					end
					CMD_APPEND: begin
						if (!full) begin
							count_q      <= count_q + CW'(1);
							classified_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (ctrl.cls_init) begin
				base_q <= '0;
				pend_q <= 1'b0;
			end
			if (ctrl.cls_step) begin
				pend_q <= issue;
				if (pend_q && (chk_q == '0)) begin
					base_q <= rd_data;
				end
				if (cls_done) begin
					mode_q       <= cmode_nx;
					classified_q <= 1'b1;
				end
			end
			if (ctrl.pick) begin
				pend_q <= 1'b0;
			end
			if (ctrl.ls_step) begin
				pend_q <= issue;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			key_q <= key;
		end
		if (ctrl.exec) begin
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			res_method_q <= METH_LINEAR;
			res_full_q   <= (cmd_q == CMD_APPEND) && full;
		end
		if (ctrl.cls_init) begin
			ptr_q   <= '0;
			cmode_q <= METH_DIRECT;
		end
		if (ctrl.cls_step || ctrl.ls_step) begin
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			chk_q <= ptr_q[AW-1:0];
		end
		if (ctrl.cls_step && pend_q) begin
			cmode_q <= cmode_nx;
			prev_q  <= rd_data;
		end
		if (ctrl.pick) begin
			res_method_q <= mode_q;
			ptr_q        <= '0;
			lo_q         <= '0;
			hi_q         <= count_q;
			eq_q         <= 1'b0;
			if (mode_q == METH_DIRECT) begin
				res_found_q <= direct_hit;
				res_idx_q   <= direct_hit ? diff[AW-1:0] : '0;
			end
		end
		if (ctrl.bs_rd) begin
			mid_q <= mid_c;
		end
		if (ctrl.bs_cmp) begin
			if (rd_data < key_q) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
				eq_q <= hit;
			end
		end
		if (ctrl.bs_fin) begin
			res_found_q <= eq_q;
			res_idx_q   <= eq_q ? hi_q[AW-1:0] : '0;
		end
		if (ctrl.ls_step && pend_q && hit) begin
			res_found_q <= 1'b1;
			res_idx_q   <= chk_q;
		end
		if (ctrl.emit) begin
			found_q       <= res_found_q;
			match_index_q <= idx_wide[INDEX_W-1:0];
			method_q      <= res_method_q;
			table_full_q  <= res_full_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_index = match_index_q;
	assign method      = method_q;
	assign table_full  = table_full_q;

endmodule
`default_nettype wire

>>> sv/akl_checker.sv
// Port checker of the adaptive key table lookup and its bind
`timescale 1ns / 1ps
`default_nettype none
module akl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] command,
	input wire logic [31:0] key,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       found,
	input wire logic [7:0] match_index,
	input wire logic [1:0] method,
	input wire logic       table_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_index)
			&& $stable(method) && $stable(table_full))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in flight");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_index == 8'd0)
		else $error("index set without a match");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !found && method == 2'd0)
		else $error("refused append carries lookup fields");

	a_method_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> method != 2'd3)
		else $error("unknown method code");

endmodule

bind adaptive_key_table_lookup akl_checker u_akl_checker (.*);
`default_nettype wire
